### rtl/core/pgcs_pkg.sv
package pgcs_pkg;

  localparam int ROWS_DEF   = 7;
  localparam int COLS_DEF   = 5;
  localparam int GLYPHS_DEF = 4;

  localparam int GLYPH_W    = 35;
  localparam int GLYPH_NUM  = 4;
  localparam int GIDX_W     = 2;
  localparam int BIT_IDX_W  = 6;
  localparam int LED_W      = 7;
  localparam int WAIT_W     = 8;
  localparam int GAP_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GLYPH_W;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COL_DWELL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_WAITS   = 3'd5;

  localparam logic [GLYPH_W-1:0] GLYPH_ZERO_RST  = 35'd4433514655;
  localparam logic [GLYPH_W-1:0] GLYPH_ONE_RST   = 35'd15621211694;
  localparam logic [GLYPH_W-1:0] GLYPH_TWO_RST   = 35'd18842441585;
  localparam logic [GLYPH_W-1:0] GLYPH_THREE_RST = 35'd15621211694;
  localparam logic [WAIT_W-1:0]  COL_DWELL_RST   = 8'd2;
  localparam logic [GAP_W-1:0]   GAP_WAITS_RST   = 32'd402916356;

  typedef struct packed {
    logic [GLYPH_NUM-1:0][GLYPH_W-1:0] glyph;
    logic [WAIT_W-1:0]                 col_dwell;
    logic [GAP_W-1:0]                  gap_waits;
  } cfg_t;

endpackage

### rtl/core/pgcs_cfg.sv
module pgcs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [pgcs_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [pgcs_pkg::CFG_DATA_W-1:0]  wr_data,
  output pgcs_pkg::cfg_t                   cfg
);
  import pgcs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph[0]  <= GLYPH_ZERO_RST;
      cfg_r.glyph[1]  <= GLYPH_ONE_RST;
      cfg_r.glyph[2]  <= GLYPH_TWO_RST;
      cfg_r.glyph[3]  <= GLYPH_THREE_RST;
      cfg_r.col_dwell <= COL_DWELL_RST;
      cfg_r.gap_waits <= GAP_WAITS_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_GLYPH_ZERO:  cfg_r.glyph[0]  <= wr_data;
        REG_GLYPH_ONE:   cfg_r.glyph[1]  <= wr_data;
        REG_GLYPH_TWO:   cfg_r.glyph[2]  <= wr_data;
        REG_GLYPH_THREE: cfg_r.glyph[3]  <= wr_data;
        REG_COL_DWELL:   cfg_r.col_dwell <= wr_data[WAIT_W-1:0];
        REG_GAP_WAITS:   cfg_r.gap_waits <= wr_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/pgcs_core.sv
module pgcs_core #(
  parameter int ROWS   = pgcs_pkg::ROWS_DEF,
  parameter int COLS   = pgcs_pkg::COLS_DEF,
  parameter int GLYPHS = pgcs_pkg::GLYPHS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         tick,
  input  pgcs_pkg::cfg_t               cfg,
  output logic [pgcs_pkg::LED_W-1:0]   led_rows,
  output logic                         refreshed
);
  import pgcs_pkg::*;

  localparam int COL_W = $clog2(COLS + 1);

  logic [WAIT_W-1:0] wait_left_r,    wait_left_nxt;
  logic [GIDX_W-1:0] glyph_index_r,  glyph_index_nxt;
  logic [COL_W-1:0]  column_index_r, column_index_nxt;
  logic [LED_W-1:0]  led_levels_r,   led_levels_nxt;

  logic [GLYPH_W-1:0] glyph_cur;
  logic [LED_W-1:0]   pattern;
  logic               acted;

  assign glyph_cur = cfg.glyph[glyph_index_r];

  always_comb begin
    logic [BIT_IDX_W-1:0] bit_idx;
    pattern = '0;
    bit_idx = '0;
    for (int r = 0; r < LED_W; r++) begin
      bit_idx = BIT_IDX_W'(r * COLS) + BIT_IDX_W'(column_index_r);
      if (r < ROWS && bit_idx < BIT_IDX_W'(GLYPH_W)) begin
        pattern[r] = glyph_cur[bit_idx];
      end
    end
  end

  always_comb begin
    wait_left_nxt    = wait_left_r;
    glyph_index_nxt  = glyph_index_r;
    column_index_nxt = column_index_r;
    led_levels_nxt   = led_levels_r;
    acted            = 1'b0;
    if (tick) begin
      if (wait_left_r > WAIT_W'(1)) begin
        wait_left_nxt = wait_left_r - WAIT_W'(1);
      end else begin
        acted = 1'b1;
        if (column_index_r >= COL_W'(COLS)) begin
          wait_left_nxt    = cfg.gap_waits[WAIT_W*glyph_index_r +: WAIT_W];
          led_levels_nxt   = '0;
          column_index_nxt = '0;
          if (glyph_index_r >= GIDX_W'(GLYPHS - 1)) begin
            glyph_index_nxt = '0;
          end else begin
            glyph_index_nxt = glyph_index_r + GIDX_W'(1);
          end
        end else begin
          led_levels_nxt   = pattern;
          wait_left_nxt    = cfg.col_dwell;
          column_index_nxt = column_index_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_left_r    <= '0;
      glyph_index_r  <= '0;
      column_index_r <= '0;
      led_levels_r   <= '0;
    end else if (step) begin
      wait_left_r    <= wait_left_nxt;
      glyph_index_r  <= glyph_index_nxt;
      column_index_r <= column_index_nxt;
      led_levels_r   <= led_levels_nxt;
    end
  end

  assign led_rows  = led_levels_nxt;
  assign refreshed = acted;

endmodule

### rtl/core/pov_glyph_column_sequencer.sv
// A result beat is registered: it appears in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle; the output register frees up in the
// same cycle its beat is taken, so the input stalls only while that is held.
// Reset (rst_n low, synchronous): LEDs off, counter, column and glyph at zero,
// fonts and waits back to their defaults, no result pending.
module pov_glyph_column_sequencer #(
  parameter int ROWS   = pgcs_pkg::ROWS_DEF,
  parameter int COLS   = pgcs_pkg::COLS_DEF,
  parameter int GLYPHS = pgcs_pkg::GLYPHS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_tick,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pgcs_pkg::LED_W-1:0]       out_led_rows,
  output logic                             out_refreshed,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pgcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pgcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pgcs_pkg::*;

  cfg_t             cfg;
  logic             accept;
  logic [LED_W-1:0] led_rows;
  logic             refreshed;

  logic             out_valid_r, out_valid_nxt;
  logic [LED_W-1:0] out_led_rows_r;
  logic             out_refreshed_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  pgcs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pgcs_core #(
    .ROWS   (ROWS),
    .COLS   (COLS),
    .GLYPHS (GLYPHS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .tick      (in_tick),
    .cfg       (cfg),
    .led_rows  (led_rows),
    .refreshed (refreshed)
  );

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_led_rows_r  <= led_rows;
      out_refreshed_r <= refreshed;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_rows  = out_led_rows_r;
  assign out_refreshed = out_refreshed_r;

endmodule

### dv/pov_glyph_column_sequencer_tb.sv
module pov_glyph_column_sequencer_tb;
  import pgcs_pkg::*;

  localparam logic [CFG_IDX_W-1:0]  REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0]  REG_UNMAPPED_HI = 3'd7;
  localparam logic [CFG_DATA_W-1:0] ALL_LIT         = 35'h7FFFFFFFF;
  localparam logic [CFG_DATA_W-1:0] NONE_LIT        = 35'h000000000;
  localparam int PLAN_LEN       = 24;
  localparam int NUM_PHASES     = 8;
  localparam int TICKS_PER_PASS = 125;
  localparam int HOLD_OFF_AT    = 350;
  localparam int HOLD_OFF_LEN   = 300;

  typedef struct packed {
    logic [LED_W-1:0] led_rows;
    logic             refreshed;
  } led_frame_t;

  typedef enum logic {ROW_TICK, ROW_REG} plan_kind_t;

  typedef struct packed {
    plan_kind_t              kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic                    tick;
    logic                    typed;
    logic [LED_W-1:0]        led;
    logic                    refreshed;
  } plan_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_tick   = 1'b0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [LED_W-1:0]      out_led_rows;
  logic                  out_refreshed;
  logic                  cfg_ready;

  cfg_t                  shadow;
  logic [WAIT_W-1:0]     dwell_left;
  logic [GIDX_W-1:0]     glyph_sel;
  logic [2:0]            col_sel;
  logic [LED_W-1:0]      leds_lit;

  led_frame_t            frames_due[$];
  led_frame_t            beat_due;
  int                    faults      = 0;
  int                    ticks_taken = 0;
  bit                    calm        = 1'b0;
  bit                    long_done   = 1'b0;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b0, 1'b1, 7'h00, 1'b0},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b1, 7'h01, 1'b1},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b0, 7'h00, 1'b0},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_REG,  REG_GLYPH_ZERO,  ALL_LIT,        1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_REG,  REG_GLYPH_ONE,   NONE_LIT,       1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_REG,  REG_COL_DWELL,   NONE_LIT,       1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_REG,  REG_GAP_WAITS,   NONE_LIT,       1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b1, 7'h7F, 1'b1},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b1, 7'h7F, 1'b1},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b1, 7'h7F, 1'b1},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b1, 7'h7F, 1'b1},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b0, 1'b1, 7'h7F, 1'b0},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b1, 7'h00, 1'b1},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b1, 7'h00, 1'b1},
    '{ROW_REG,  REG_COL_DWELL,   ALL_LIT,        1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_REG,  REG_GAP_WAITS,   ALL_LIT,        1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_REG,  REG_GLYPH_TWO,   35'h2AAAAAAAA,  1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_REG,  REG_GLYPH_THREE, 35'h555555555,  1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b0, 7'h00, 1'b0},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b0, 7'h00, 1'b0},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_REG,  REG_UNMAPPED_HI, ALL_LIT,        1'b0, 1'b0, 7'h00, 1'b0},
    '{ROW_TICK, REG_GLYPH_ZERO,  NONE_LIT,       1'b1, 1'b0, 7'h00, 1'b0}
  };

  pov_glyph_column_sequencer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_tick       (in_tick),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_led_rows  (out_led_rows),
    .out_refreshed (out_refreshed),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic led_frame_t next_led_frame(input logic tick);
    led_frame_t          frame;
    logic [GLYPH_W-1:0]  bitmap;
    frame.refreshed = 1'b0;
    if (tick) begin
      if (dwell_left > 1) begin
        dwell_left = dwell_left - 1'b1;
      end else begin
        frame.refreshed = 1'b1;
        if (col_sel >= COLS_DEF) begin
          dwell_left = shadow.gap_waits[8*glyph_sel +: 8];
          leds_lit   = '0;
          col_sel    = '0;
          glyph_sel  = GIDX_W'((glyph_sel + 1) % GLYPHS_DEF);
        end else begin
          bitmap = shadow.glyph[glyph_sel];
          for (int r = 0; r < ROWS_DEF; r++) leds_lit[r] = bitmap[r*COLS_DEF + col_sel];
          dwell_left = shadow.col_dwell;
          col_sel    = col_sel + 1'b1;
        end
      end
    end
    frame.led_rows = leds_lit;
    return frame;
  endfunction

  function automatic logic [7:0] pick_wait();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 8'hFF;
    if (roll < 4)  return 8'h00;
    if (roll < 7)  return 8'h01;
    return 8'($urandom_range(2, 4));
  endfunction

  task automatic offer_tick(input logic tick, input logic typed, input led_frame_t typed_frame);
    led_frame_t frame;
    in_valid <= 1'b1;
    in_tick  <= tick;
    do @(posedge clk); while (in_stall);
    frame = next_led_frame(tick);
    if (typed) frame = typed_frame;
    frames_due.push_back(frame);
    ticks_taken++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GLYPH_ZERO, REG_GLYPH_ONE, REG_GLYPH_TWO, REG_GLYPH_THREE: begin
        shadow.glyph[idx[1:0]] = data;
      end
      REG_COL_DWELL: begin
        shadow.col_dwell = data[WAIT_W-1:0];
      end
      REG_GAP_WAITS: begin
        shadow.gap_waits = data[GAP_W-1:0];
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold off in bursts; one long hold-off to back the block up
  initial begin
    forever begin
      @(posedge clk);
      if (calm) begin
        out_stall <= 1'b0;
      end else if (!long_done && ticks_taken >= HOLD_OFF_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        out_stall <= 1'b0;
        long_done = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $error("result beat with nothing outstanding: led_rows %0h refreshed %0b",
               out_led_rows, out_refreshed);
        faults++;
      end else begin
        beat_due = frames_due.pop_front();
        if (out_led_rows !== beat_due.led_rows) begin
          $error("led_rows: expected %0h, actual %0h", beat_due.led_rows, out_led_rows);
          faults++;
        end
        if (out_refreshed !== beat_due.refreshed) begin
          $error("refreshed: expected %0b, actual %0b", beat_due.refreshed, out_refreshed);
          faults++;
        end
      end
    end
  end

  initial begin
    led_frame_t        typed_frame;
    logic [63:0]       r;
    logic [WAIT_W-1:0] lw;
    logic [GAP_W-1:0]  gw;
    shadow.glyph[0]  = GLYPH_ZERO_RST;
    shadow.glyph[1]  = GLYPH_ONE_RST;
    shadow.glyph[2]  = GLYPH_TWO_RST;
    shadow.glyph[3]  = GLYPH_THREE_RST;
    shadow.col_dwell = COL_DWELL_RST;
    shadow.gap_waits = GAP_WAITS_RST;
    dwell_left = '0;
    glyph_sel  = '0;
    col_sel    = '0;
    leds_lit   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_REG) begin
        drain_frames();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        typed_frame.led_rows  = plan[i].led;
        typed_frame.refreshed = plan[i].refreshed;
        offer_tick(plan[i].tick, plan[i].typed, typed_frame);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_frames();
      for (int g = 0; g < GLYPH_NUM; g++) begin
        r = {$urandom(), $urandom()};
        write_reg(CFG_IDX_W'(REG_GLYPH_ZERO + g), r[CFG_DATA_W-1:0]);
      end
      if (p == 0) begin
        lw = 8'h00;
        gw = 32'h0;
      end else if (p == 1) begin
        lw = 8'hFF;
        gw = 32'hFFFFFFFF;
      end else begin
        lw = pick_wait();
        gw = {pick_wait(), pick_wait(), pick_wait(), pick_wait()};
      end
      r = {$urandom(), $urandom()};
      write_reg(REG_COL_DWELL, {r[CFG_DATA_W-WAIT_W-1:0], lw});
      write_reg(REG_GAP_WAITS, {r[CFG_DATA_W-1:GAP_W], gw});
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                  r[CFG_DATA_W-1:0]);
      end
      if (p == NUM_PHASES - 1) calm = 1'b1;
      typed_frame = '0;
      for (int k = 0; k < TICKS_PER_PASS; k++) begin
        offer_tick($urandom_range(0, 9) != 0, 1'b0, typed_frame);
      end
    end

    drain_frames();
    repeat (4) @(posedge clk);
    if (frames_due.size() != 0) begin
      $error("%0d result beats never arrived", frames_due.size());
      faults++;
    end
    if (faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
